>>> rtl/ffha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ffha_pkg;

    localparam int ADDR_W = 24;
    localparam int MODE_W = 2;
    localparam int ST_W   = 3;

    localparam int MAX_FREE_DEF     = 64;
    localparam int MAX_USED_DEF     = 64;
    localparam int HEADER_BYTES_DEF = 32;

    localparam logic [ADDR_W-1:0] HEAP_SIZE_RESET = ADDR_W'(8192000 * 2);
    localparam int ROUND_ADD   = 15;
    localparam int SPLIT_SLACK = 16;

    localparam logic [MODE_W-1:0] MODE_INIT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_NOFIT   = 3'd1;
    localparam logic [ST_W-1:0] ST_NULL    = 3'd2;
    localparam logic [ST_W-1:0] ST_UNKNOWN = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd4;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_BOOT,
        OP_LOAD,
        OP_INIT,
        OP_FRD,
        OP_IDX_INC,
        OP_FIT_CAP,
        OP_SLOT_INC,
        OP_A_TAKE,
        OP_A_SUB,
        OP_A_BASE,
        OP_A_REC,
        OP_CNT_DEC,
        OP_RM_RD,
        OP_RM_WR,
        OP_URD,
        OP_U_CAP,
        OP_PREV_CAP,
        OP_NEXT_CAP,
        OP_F_SUM,
        OP_F_N,
        OP_F_PN,
        OP_F_P,
        OP_SH_INIT,
        OP_SH_RD,
        OP_SH_WR,
        OP_F_INS,
        OP_PUT
    } ffha_op_t;

    typedef struct packed {
        ffha_op_t        op;
        logic [ST_W-1:0] code;
    } ffha_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              faddr_zero;
        logic              idx_end;
        logic              fit;
        logic              take_whole;
        logic              base_le;
        logic              slot_end;
        logic              slot_used;
        logic              match;
        logic              prev;
        logic              next;
        logic              full;
        logic              rm_last;
        logic              sh_done;
        logic              out_free;
    } ffha_sts_t;

endpackage

`default_nettype wire

>>> rtl/ffha_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface ffha_req_if;
    import ffha_pkg::*;
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [ADDR_W-1:0]   request_size;
    logic [ADDR_W-1:0]   free_address;
    modport source (output valid, output mode, output request_size, output free_address,
                    input ready);
    modport sink (input valid, input mode, input request_size, input free_address,
                  output ready);
endinterface

interface ffha_rsp_if;
    import ffha_pkg::*;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] address;
    logic [ST_W-1:0]   status;
    modport source (output valid, output address, output status, input ready);
    modport sink (input valid, input address, input status, output ready);
endinterface

interface ffha_cfg_if;
    import ffha_pkg::*;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] heap_size;
    modport source (output valid, output heap_size, input ready);
    modport sink (input valid, input heap_size, output ready);
endinterface

`default_nettype wire

>>> rtl/ffha_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module ffha_dpath #(
    parameter int MAX_FREE     = ffha_pkg::MAX_FREE_DEF,
    parameter int MAX_USED     = ffha_pkg::MAX_USED_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ffha_pkg::ffha_cmd_t               cmd,
    output ffha_pkg::ffha_sts_t               sts,
    input  logic [ffha_pkg::MODE_W-1:0]       req_mode,
    input  logic [ffha_pkg::ADDR_W-1:0]       req_size,
    input  logic [ffha_pkg::ADDR_W-1:0]       req_faddr,
    input  logic                              cfg_valid,
    input  logic [ffha_pkg::ADDR_W-1:0]       cfg_data,
    output logic                              cfg_ready,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output logic [ffha_pkg::ADDR_W-1:0]       rsp_address,
    output logic [ffha_pkg::ST_W-1:0]         rsp_status
);
    import ffha_pkg::*;

    localparam int FCW = $clog2(MAX_FREE + 1);
    localparam int FIW = $clog2(MAX_FREE);
    localparam int UCW = $clog2(MAX_USED + 1);
    localparam int UIW = $clog2(MAX_USED);
    localparam int RW  = ADDR_W + 1;
    localparam int TW  = ADDR_W + 2;
    localparam int EW  = 2 * ADDR_W;

    // control state
    logic [ADDR_W-1:0]   heap_size_reg, heap_size_next;
    logic [FCW-1:0]      free_count_reg, free_count_next;
    logic [MAX_USED-1:0] used_valid_reg, used_valid_next;
    logic                out_valid_reg, out_valid_next;

    // working registers
    logic [MODE_W-1:0] mode_reg;
    logic [ADDR_W-1:0] faddr_reg;
    logic [RW-1:0]     rnd_reg;
    logic [FCW-1:0]    idx_reg, q_reg;
    logic [UCW-1:0]    slot_reg;
    logic [ADDR_W-1:0] fit_base_reg, fit_len_reg;
    logic [ADDR_W-1:0] blk_reg, len_reg;
    logic [ADDR_W-1:0] prev_base_reg, prev_len_reg;
    logic [ADDR_W-1:0] next_base_reg, next_len_reg;
    logic              has_next_reg;
    logic [ADDR_W-1:0] merged_reg;
    logic [ADDR_W-1:0] addr_res_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic [ST_W-1:0]   out_status_reg;

    // tables
    logic [EW-1:0] free_mem [MAX_FREE];
    logic [EW-1:0] used_mem [MAX_USED];
    logic [EW-1:0] fr_rdata_reg, us_rdata_reg;

    logic              fwe, fre;
    logic [FIW-1:0]    fwa, fra;
    logic [EW-1:0]     fwd;
    logic              uwe, ure;

    logic [ADDR_W-1:0] fr_base, fr_len, us_base, us_len;
    logic [TW-1:0]     total;
    logic [FCW-1:0]    idx_p1, idx_m1, q_m1;

    assign {fr_base, fr_len} = fr_rdata_reg;
    assign {us_base, us_len} = us_rdata_reg;
    assign total  = {1'b0, rnd_reg} + TW'(HEADER_BYTES);
    assign idx_p1 = idx_reg + FCW'(1);
    assign idx_m1 = idx_reg - FCW'(1);
    assign q_m1   = q_reg - FCW'(1);

    always_comb
    begin
        sts.mode       = mode_reg;
        sts.faddr_zero = (faddr_reg == '0);
        sts.idx_end    = (idx_reg >= free_count_reg);
        sts.fit        = ({2'b00, fr_len} >= total);
        sts.take_whole = ({2'b00, fit_len_reg}
                          < ({1'b0, rnd_reg} + TW'(2 * HEADER_BYTES + SPLIT_SLACK)));
        sts.base_le    = (fr_base <= blk_reg);
        sts.slot_end   = (slot_reg >= UCW'(MAX_USED));
        sts.slot_used  = used_valid_reg[slot_reg[UIW-1:0]];
        sts.match      = (({1'b0, us_base} + RW'(HEADER_BYTES)) == {1'b0, faddr_reg});
        sts.prev       = (idx_reg != '0)
                         && (({1'b0, prev_base_reg} + {1'b0, prev_len_reg}) == {1'b0, blk_reg});
        sts.next       = has_next_reg
                         && (({1'b0, blk_reg} + {1'b0, len_reg}) == {1'b0, next_base_reg});
        sts.full       = (free_count_reg >= FCW'(MAX_FREE));
        sts.rm_last    = (idx_p1 >= free_count_reg);
        sts.sh_done    = (q_reg <= idx_reg);
        sts.out_free   = !out_valid_reg || rsp_ready;
    end

    // table port selection
    always_comb
    begin
        fwe = 1'b0;
        fre = 1'b0;
        fwa = idx_reg[FIW-1:0];
        fra = idx_reg[FIW-1:0];
        fwd = {blk_reg, len_reg};
        uwe = 1'b0;
        ure = 1'b0;
        case (cmd.op)
            OP_BOOT:
            begin
                fwe = 1'b1;
                fwa = '0;
                fwd = {{ADDR_W{1'b0}}, HEAP_SIZE_RESET};
            end
            OP_INIT:
            begin
                fwe = 1'b1;
                fwa = '0;
                fwd = {{ADDR_W{1'b0}}, heap_size_reg};
            end
            OP_FRD:    fre = 1'b1;
            OP_A_BASE:
            begin
                fwe = 1'b1;
                fwd = {fit_base_reg, len_reg};
            end
            OP_A_REC:  uwe = 1'b1;
            OP_RM_RD:
            begin
                fre = 1'b1;
                fra = idx_p1[FIW-1:0];
            end
            OP_RM_WR:
            begin
                fwe = 1'b1;
                fwd = fr_rdata_reg;
            end
            OP_URD:    ure = 1'b1;
            OP_F_N:
            begin
                fwe = 1'b1;
                fwd = {blk_reg, next_len_reg + len_reg};
            end
            OP_F_PN:
            begin
                fwe = 1'b1;
                fwa = idx_m1[FIW-1:0];
                fwd = {prev_base_reg, merged_reg + next_len_reg};
            end
            OP_F_P:
            begin
                fwe = 1'b1;
                fwa = idx_m1[FIW-1:0];
                fwd = {prev_base_reg, merged_reg};
            end
            OP_SH_RD:
            begin
                fre = 1'b1;
                fra = q_m1[FIW-1:0];
            end
            OP_SH_WR:
            begin
                fwe = 1'b1;
                fwa = q_reg[FIW-1:0];
                fwd = fr_rdata_reg;
            end
            OP_F_INS:
            begin
                fwe = 1'b1;
                fwd = {blk_reg, len_reg};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (fwe)
            free_mem[fwa] <= fwd;
        if (fre)
            fr_rdata_reg <= free_mem[fra];
    end

    always_ff @(posedge clk)
    begin
        if (uwe)
            used_mem[slot_reg[UIW-1:0]] <= {blk_reg, len_reg};
        if (ure)
            us_rdata_reg <= used_mem[slot_reg[UIW-1:0]];
    end

    always_comb
    begin
        heap_size_next  = heap_size_reg;
        free_count_next = free_count_reg;
        used_valid_next = used_valid_reg;
        out_valid_next  = out_valid_reg;
        if (cfg_valid)
            heap_size_next = cfg_data;
        if (rsp_ready)
            out_valid_next = 1'b0;
        case (cmd.op)
            OP_INIT:
            begin
                free_count_next = FCW'(1);
                used_valid_next = '0;
            end
            OP_A_REC:  used_valid_next[slot_reg[UIW-1:0]] = 1'b1;
            OP_CNT_DEC: free_count_next = free_count_reg - FCW'(1);
            OP_F_N, OP_F_PN, OP_F_P:
                used_valid_next[slot_reg[UIW-1:0]] = 1'b0;
            OP_F_INS:
            begin
                used_valid_next[slot_reg[UIW-1:0]] = 1'b0;
                free_count_next = free_count_reg + FCW'(1);
            end
            OP_PUT:    out_valid_next = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_size_reg  <= HEAP_SIZE_RESET;
            free_count_reg <= FCW'(1);
            used_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            heap_size_reg  <= heap_size_next;
            free_count_reg <= free_count_next;
            used_valid_reg <= used_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                mode_reg     <= req_mode;
                faddr_reg    <= req_faddr;
                // round up to a 16-byte grain
                rnd_reg      <= ({1'b0, req_size} + RW'(ROUND_ADD)) & ~RW'(ROUND_ADD);
                idx_reg      <= '0;
                slot_reg     <= '0;
                has_next_reg <= 1'b0;
                addr_res_reg <= '0;
            end
            OP_IDX_INC: idx_reg <= idx_p1;
            OP_FIT_CAP:
            begin
                fit_base_reg <= fr_base;
                fit_len_reg  <= fr_len;
            end
            OP_SLOT_INC: slot_reg <= slot_reg + UCW'(1);
            OP_A_TAKE:
            begin
                blk_reg <= fit_base_reg;
                len_reg <= fit_len_reg;
            end
            OP_A_SUB:  len_reg <= fit_len_reg - total[ADDR_W-1:0];
            OP_A_BASE:
            begin
                // block is carved from the top of the extent
                blk_reg <= fit_base_reg + len_reg;
                len_reg <= total[ADDR_W-1:0];
            end
            OP_A_REC:  addr_res_reg <= blk_reg + ADDR_W'(HEADER_BYTES);
            OP_RM_WR:  idx_reg <= idx_p1;
            OP_U_CAP:
            begin
                blk_reg <= us_base;
                len_reg <= us_len;
            end
            OP_PREV_CAP:
            begin
                prev_base_reg <= fr_base;
                prev_len_reg  <= fr_len;
                idx_reg       <= idx_p1;
            end
            OP_NEXT_CAP:
            begin
                next_base_reg <= fr_base;
                next_len_reg  <= fr_len;
                has_next_reg  <= 1'b1;
            end
            OP_F_SUM:  merged_reg <= prev_len_reg + len_reg;
            OP_SH_INIT: q_reg <= free_count_reg;
            OP_SH_WR:  q_reg <= q_m1;
            OP_PUT:
            begin
                out_addr_reg   <= addr_res_reg;
                out_status_reg <= cmd.code;
            end
            default: ;
        endcase
    end

    assign cfg_ready   = 1'b1;
    assign rsp_valid   = out_valid_reg;
    assign rsp_address = out_addr_reg;
    assign rsp_status  = out_status_reg;

endmodule

`default_nettype wire

>>> rtl/ffha_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ffha_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    output ffha_pkg::ffha_cmd_t cmd,
    input  ffha_pkg::ffha_sts_t sts
);
    import ffha_pkg::*;

    typedef enum logic [4:0] {
        S_BOOT, S_IDLE, S_DISP, S_INIT,
        S_AF_RD, S_AF_CK, S_AU_CK, S_A_BASE, S_A_REC,
        S_RM_RD, S_RM_WR,
        S_FU_CK, S_FU_CMP, S_FP_RD, S_FP_CK, S_F_DEC, S_F_PN, S_F_P,
        S_SH_RD, S_SH_WR,
        S_RESP
    } state_t;

    state_t          state_reg, state_next;
    logic [ST_W-1:0] code_reg, code_next;

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd.op     = OP_NONE;
        cmd.code   = code_reg;
        req_ready  = 1'b0;
        case (state_reg)
            S_BOOT:
            begin
                cmd.op     = OP_BOOT;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.op     = OP_LOAD;
                    code_next  = ST_OK;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (sts.mode)
                    MODE_INIT:  state_next = S_INIT;
                    MODE_ALLOC: state_next = S_AF_RD;
                    MODE_FREE:
                    begin
                        if (sts.faddr_zero)
                        begin
                            code_next  = ST_NULL;
                            state_next = S_RESP;
                        end
                        else
                            state_next = S_FU_CK;
                    end
                    default:    state_next = S_RESP;
                endcase
            end
            S_INIT:
            begin
                cmd.op     = OP_INIT;
                state_next = S_RESP;
            end
            S_AF_RD:
            begin
                if (sts.idx_end)
                begin
                    code_next  = ST_NOFIT;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.op     = OP_FRD;
                    state_next = S_AF_CK;
                end
            end
            S_AF_CK:
            begin
                if (sts.fit)
                begin
                    cmd.op     = OP_FIT_CAP;
                    state_next = S_AU_CK;
                end
                else
                begin
                    cmd.op     = OP_IDX_INC;
                    state_next = S_AF_RD;
                end
            end
            S_AU_CK:
            begin
                if (sts.slot_end)
                begin
                    code_next  = ST_FULL;
                    state_next = S_RESP;
                end
                else if (sts.slot_used)
                    cmd.op = OP_SLOT_INC;
                else if (sts.take_whole)
                begin
                    // leftover too small to keep: take the whole extent
                    cmd.op     = OP_A_TAKE;
                    state_next = S_A_REC;
                end
                else
                begin
                    cmd.op     = OP_A_SUB;
                    state_next = S_A_BASE;
                end
            end
            S_A_BASE:
            begin
                cmd.op     = OP_A_BASE;
                state_next = S_A_REC;
            end
            S_A_REC:
            begin
                cmd.op     = OP_A_REC;
                state_next = sts.take_whole ? S_RM_RD : S_RESP;
            end
            S_RM_RD:
            begin
                if (sts.rm_last)
                begin
                    cmd.op     = OP_CNT_DEC;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.op     = OP_RM_RD;
                    state_next = S_RM_WR;
                end
            end
            S_RM_WR:
            begin
                cmd.op     = OP_RM_WR;
                state_next = S_RM_RD;
            end
            S_FU_CK:
            begin
                if (sts.slot_end)
                begin
                    code_next  = ST_UNKNOWN;
                    state_next = S_RESP;
                end
                else if (!sts.slot_used)
                    cmd.op = OP_SLOT_INC;
                else
                begin
                    cmd.op     = OP_URD;
                    state_next = S_FU_CMP;
                end
            end
            S_FU_CMP:
            begin
                if (sts.match)
                begin
                    cmd.op     = OP_U_CAP;
                    state_next = S_FP_RD;
                end
                else
                begin
                    cmd.op     = OP_SLOT_INC;
                    state_next = S_FU_CK;
                end
            end
            S_FP_RD:
            begin
                if (sts.idx_end)
                    state_next = S_F_DEC;
                else
                begin
                    cmd.op     = OP_FRD;
                    state_next = S_FP_CK;
                end
            end
            S_FP_CK:
            begin
                if (sts.base_le)
                begin
                    cmd.op     = OP_PREV_CAP;
                    state_next = S_FP_RD;
                end
                else
                begin
                    cmd.op     = OP_NEXT_CAP;
                    state_next = S_F_DEC;
                end
            end
            S_F_DEC:
            begin
                if (sts.prev && sts.next)
                begin
                    cmd.op     = OP_F_SUM;
                    state_next = S_F_PN;
                end
                else if (sts.prev)
                begin
                    cmd.op     = OP_F_SUM;
                    state_next = S_F_P;
                end
                else if (sts.next)
                begin
                    cmd.op     = OP_F_N;
                    state_next = S_RESP;
                end
                else if (sts.full)
                begin
                    code_next  = ST_FULL;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.op     = OP_SH_INIT;
                    state_next = S_SH_RD;
                end
            end
            S_F_PN:
            begin
                // both neighbours merged: drop the upper extent
                cmd.op     = OP_F_PN;
                state_next = S_RM_RD;
            end
            S_F_P:
            begin
                cmd.op     = OP_F_P;
                state_next = S_RESP;
            end
            S_SH_RD:
            begin
                if (sts.sh_done)
                begin
                    cmd.op     = OP_F_INS;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.op     = OP_SH_RD;
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                cmd.op     = OP_SH_WR;
                state_next = S_SH_RD;
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_PUT;
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_BOOT;
            code_reg  <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/first_fit_heap_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  handshake      payload
// req      in   valid / ready  mode, request_size, free_address
// rsp      out  valid / ready  address, status
// cfg      in   valid / ready  heap_size (always ready)
//
// one item at a time; a new item is taken once the previous result is in the output register
// init rewrites the extent table; alloc scans extents to the fit, probes used slots, records the block
// and moves extents on removal; free searches used slots, scans extents and moves extents
// the worst case is set by the used-slot search and extent table walk
// after reset the boot state writes the initial extent before req goes ready
// a stalled rsp holds the result and blocks only the next result

module first_fit_heap_allocator_unit #(
    parameter int MAX_FREE     = ffha_pkg::MAX_FREE_DEF,
    parameter int MAX_USED     = ffha_pkg::MAX_USED_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    ffha_req_if.sink          req,
    ffha_rsp_if.source        rsp,
    ffha_cfg_if.sink          cfg
);
    import ffha_pkg::*;

    ffha_cmd_t         cmd;
    ffha_sts_t         sts;
    logic              rsp_valid;
    logic [ADDR_W-1:0] rsp_address;
    logic [ST_W-1:0]   rsp_status;
    logic              cfg_ready;
    logic              req_ready;

    ffha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    ffha_dpath #(
        .MAX_FREE     (MAX_FREE),
        .MAX_USED     (MAX_USED),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .req_mode    (req.mode),
        .req_size    (req.request_size),
        .req_faddr   (req.free_address),
        .cfg_valid   (cfg.valid),
        .cfg_data    (cfg.heap_size),
        .cfg_ready   (cfg_ready),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp.ready),
        .rsp_address (rsp_address),
        .rsp_status  (rsp_status)
    );

    assign req.ready   = req_ready;
    assign cfg.ready   = cfg_ready;
    assign rsp.valid   = rsp_valid;
    assign rsp.address = rsp_address;
    assign rsp.status  = rsp_status;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("req ready while an item is in progress");

    a_addr_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_OK) |-> (rsp.address == '0))
        else $error("address given with an error status");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.status == ST_OK || rsp.status == ST_NOFIT || rsp.status == ST_NULL
                       || rsp.status == ST_UNKNOWN || rsp.status == ST_FULL))
        else $error("undefined status code");
`endif

endmodule

`default_nettype wire

>>> tb/tb_ifs.sv
`timescale 1ns / 1ps

// channel interfaces come from the rtl file ffha_ifs.sv; this file only keeps the scoreboard class
package tb_sb_pkg;
    import ffha_pkg::*;

    class heap_scoreboard;
        logic [ADDR_W-1:0] exp_addr[$];
        logic [ST_W-1:0]   exp_status[$];
        int errors;

        function void note(input logic [ADDR_W-1:0] a, input logic [ST_W-1:0] s);
            exp_addr.push_back(a);
            exp_status.push_back(s);
        endfunction

        function void check(input logic [ADDR_W-1:0] a, input logic [ST_W-1:0] s);
            logic [ADDR_W-1:0] ea;
            logic [ST_W-1:0]   es;
            if (exp_addr.size() == 0)
            begin
                report($sformatf("unexpected result address %0d status %0d", a, s));
                return;
            end
            ea = exp_addr.pop_front();
            es = exp_status.pop_front();
            if (a !== ea)
                report($sformatf("address %0d, expected %0d", a, ea));
            if (s !== es)
                report($sformatf("status %0d, expected %0d", s, es));
        endfunction

        function void report(input string msg);
            $display("mismatch: %s", msg);
            errors++;
        endfunction
    endclass
endpackage

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ffha_pkg::*;
    import tb_sb_pkg::*;

    localparam int NFREE = MAX_FREE_DEF;
    localparam int NUSED = MAX_USED_DEF;
    localparam int HDR   = HEADER_BYTES_DEF;

    logic clk = 0;
    logic rst_n = 0;
    always #1 clk = ~clk;

    ffha_req_if req();
    ffha_rsp_if rsp();
    ffha_cfg_if cfg();

    first_fit_heap_allocator_unit dut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp), .cfg(cfg));

    heap_scoreboard sb = new();

    // heap model
    logic [ADDR_W-1:0] heap_size;
    logic [ADDR_W-1:0] fbase[NFREE];
    logic [ADDR_W-1:0] flen[NFREE];
    int                fcount;
    logic [ADDR_W-1:0] ubase[NUSED];
    logic [ADDR_W-1:0] ulen[NUSED];
    bit                uvalid[NUSED];
    logic [ADDR_W-1:0] live_addr[$];
    bit quiet_req, quiet_rsp;
    int sent;

    function void heap_rebuild();
        for (int i = 0; i < NFREE; i++)
        begin
            fbase[i] = 0;
            flen[i] = 0;
        end
        for (int i = 0; i < NUSED; i++)
            uvalid[i] = 0;
        flen[0] = heap_size;
        fcount = 1;
        live_addr.delete();
    endfunction

    function void extent_remove(input int p);
        for (int i = p; i + 1 < fcount; i++)
        begin
            fbase[i] = fbase[i+1];
            flen[i] = flen[i+1];
        end
        fcount--;
    endfunction

    function void heap_alloc(input logic [ADDR_W-1:0] rq, output logic [ADDR_W-1:0] a,
                             output logic [ST_W-1:0] st);
        longint total;
        int fit, slot;
        logic [ADDR_W-1:0] blk, len;
        total = ((longint'(rq) + ROUND_ADD) & ~longint'(15)) + HDR;
        a = 0;
        fit = -1;
        slot = -1;
        for (int i = 0; i < fcount; i++)
            if (fit < 0 && longint'(flen[i]) >= total)
                fit = i;
        if (fit < 0)
        begin
            st = ST_NOFIT;
            return;
        end
        for (int s = 0; s < NUSED; s++)
            if (slot < 0 && !uvalid[s])
                slot = s;
        if (slot < 0)
        begin
            st = ST_FULL;
            return;
        end
        if (longint'(flen[fit]) < total + HDR + SPLIT_SLACK)
        begin
            blk = fbase[fit];
            len = flen[fit];
            extent_remove(fit);
        end
        else
        begin
            flen[fit] = flen[fit] - ADDR_W'(total);
            blk = fbase[fit] + flen[fit];
            len = ADDR_W'(total);
        end
        ubase[slot] = blk;
        ulen[slot] = len;
        uvalid[slot] = 1;
        a = blk + ADDR_W'(HDR);
        live_addr.push_back(a);
        st = ST_OK;
    endfunction

    function void heap_release(input logic [ADDR_W-1:0] fa, output logic [ST_W-1:0] st);
        int slot, p;
        bit prv, nxt;
        logic [ADDR_W-1:0] blk, len;
        if (fa == 0)
        begin
            st = ST_NULL;
            return;
        end
        slot = -1;
        for (int s = 0; s < NUSED; s++)
            if (slot < 0 && uvalid[s] && longint'(ubase[s]) + HDR == longint'(fa))
                slot = s;
        if (slot < 0)
        begin
            st = ST_UNKNOWN;
            return;
        end
        blk = ubase[slot];
        len = ulen[slot];
        p = 0;
        while (p < fcount && fbase[p] <= blk)
            p++;
        nxt = p < fcount && longint'(blk) + len == longint'(fbase[p]);
        prv = p > 0 && longint'(fbase[p-1]) + flen[p-1] == longint'(blk);
        if (prv && nxt)
        begin
            flen[p-1] = flen[p-1] + len + flen[p];
            extent_remove(p);
        end
        else if (prv)
            flen[p-1] = flen[p-1] + len;
        else if (nxt)
        begin
            fbase[p] = blk;
            flen[p] = flen[p] + len;
        end
        else
        begin
            if (fcount >= NFREE)
            begin
                st = ST_FULL;
                return;
            end
            for (int i = fcount; i > p; i--)
            begin
                fbase[i] = fbase[i-1];
                flen[i] = flen[i-1];
            end
            fbase[p] = blk;
            flen[p] = len;
            fcount++;
        end
        uvalid[slot] = 0;
        foreach (live_addr[k])
            if (live_addr[k] == fa)
            begin
                live_addr.delete(k);
                break;
            end
        st = ST_OK;
    endfunction

    function void heap_predict(input logic [MODE_W-1:0] m, input logic [ADDR_W-1:0] rq,
                               input logic [ADDR_W-1:0] fa);
        logic [ADDR_W-1:0] a;
        logic [ST_W-1:0] st;
        a = 0;
        st = ST_OK;
        if (m == MODE_INIT)
            heap_rebuild();
        else if (m == MODE_ALLOC)
            heap_alloc(rq, a, st);
        else if (m == MODE_FREE)
            heap_release(fa, st);
        sb.note(a, st);
    endfunction

    // valid stays high after an accept until the next idle cycle or the next item
    task automatic send_item(input logic [MODE_W-1:0] m, input logic [ADDR_W-1:0] rq,
                             input logic [ADDR_W-1:0] fa);
        while (!quiet_req && $urandom_range(99) < 11)
        begin
            req.valid <= 0;
            @(posedge clk);
        end
        req.valid <= 1;
        req.mode <= m;
        req.request_size <= rq;
        req.free_address <= fa;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        heap_predict(m, rq, fa);
        sent++;
    endtask

    task automatic write_heap_size(input logic [ADDR_W-1:0] v);
        req.valid <= 0;
        while (sb.exp_addr.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        cfg.valid <= 1;
        cfg.heap_size <= v;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        heap_size = v;
        cfg.valid <= 0;
    endtask

    // mostly modest requests, a few huge ones, plus frees of live and junk addresses, rare inits and bad modes
    task automatic random_item();
        int r;
        logic [ADDR_W-1:0] rq, fa;
        r = $urandom_range(99);
        rq = $urandom_range(3) == 0 ? ADDR_W'($urandom) : ADDR_W'($urandom_range(600));
        fa = ADDR_W'($urandom);
        if (live_addr.size() > 0 && $urandom_range(9) < 8)
            fa = live_addr[$urandom_range(live_addr.size() - 1)];
        if (r < 2)
            send_item(MODE_INIT, rq, fa);
        else if (r < 4)
            send_item(2'd3, rq, fa);
        else if (r < 52)
            send_item(MODE_ALLOC, rq, fa);
        else
            send_item(MODE_FREE, rq, fa);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
            sb.check(rsp.address, rsp.status);
        if (!rst_n)
            rsp.ready <= 0;
        else
            rsp.ready <= quiet_rsp || $urandom_range(99) >= 11;
    end

    initial
    begin
        req.valid = 0;
        req.mode = MODE_INIT;
        req.request_size = 0;
        req.free_address = 0;
        cfg.valid = 0;
        cfg.heap_size = 0;
        rsp.ready = 0;
        quiet_req = 0;
        quiet_rsp = 0;
        sent = 0;
        heap_size = HEAP_SIZE_RESET;
        heap_rebuild();
        repeat (8) @(posedge clk);
        rst_n <= 1;

        // directed
        send_item(MODE_FREE, 0, 0);
        send_item(MODE_FREE, 0, 24'hFFFFFF);
        send_item(MODE_ALLOC, 0, 0);
        send_item(MODE_ALLOC, 1, 0);
        send_item(MODE_ALLOC, 24'hFFFFFF, 0);
        send_item(2'd3, 24'hFFFFFF, 24'hFFFFFF);
        send_item(MODE_FREE, 0, live_addr[0]);
        send_item(MODE_FREE, 0, live_addr[0]);
        send_item(MODE_FREE, 0, live_addr[0]);
        write_heap_size(0);
        send_item(MODE_INIT, 0, 0);
        send_item(MODE_ALLOC, 0, 0);
        write_heap_size(24'hFFFFFF);
        send_item(MODE_INIT, 0, 0);
        send_item(MODE_ALLOC, 24'hFFFFC0, 0);
        send_item(MODE_ALLOC, 24'hFFFFDF, 0);
        // extent exhaustion on a tiny heap, then used table fill-up on a roomy heap
        write_heap_size(64);
        send_item(MODE_INIT, 0, 0);
        send_item(MODE_ALLOC, 16, 0);
        send_item(MODE_ALLOC, 0, 0);
        send_item(MODE_ALLOC, 0, 0);
        write_heap_size(100000);
        send_item(MODE_INIT, 0, 0);
        repeat (70)
            send_item(MODE_ALLOC, 0, 0);
        // frees on a 96-byte stride; the blocks above are 32 bytes apart, so the loop's frees match none of them
        for (int k = 0; k < 64; k += 2)
            send_item(MODE_FREE, 0, ADDR_W'(100000 - 48 * (k + 1) + HDR));
        send_item(MODE_FREE, 0, ADDR_W'(100000 - 48 * 64 + HDR));
        send_item(MODE_FREE, 0, ADDR_W'(100000 - 48 * 2 + HDR));

        // random phases over several heap sizes
        for (int ph = 0; ph < 4; ph++)
        begin
            quiet_req = ph == 2;
            quiet_rsp = ph == 2;
            if (ph == 1)
                write_heap_size(ADDR_W'($urandom_range(4000, 64)));
            else if (ph == 2)
                write_heap_size(24'hFFFFFF);
            else if (ph == 3)
                write_heap_size(ADDR_W'($urandom));
            else
                write_heap_size(20000);
            send_item(MODE_INIT, 0, 0);
            repeat (250)
                random_item();
        end
        quiet_req = 0;
        quiet_rsp = 0;

        req.valid <= 0;
        while (sb.exp_addr.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end
endmodule
